// ===== hdl/spq_pkg.sv =====
// Shared types and constants of the scale pitch quantizer.
`timescale 1ns / 1ps
package spq_pkg;
    localparam int FREQ_W    = 18;
    localparam int NOTE_W    = 7;
    localparam int RATIO_W   = 17;
    localparam int CHAIN_LEN = 33;
    localparam int KIDX_W    = 6;

    localparam logic [1:0] ST_MATCH = 2'd0;
    localparam logic [1:0] ST_NOBAND = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_CONCERT = 2'd0;
    localparam logic [1:0] REG_KEY = 2'd1;
    localparam logic [1:0] REG_OMIT = 2'd2;
    localparam logic [1:0] REG_SHIFT = 2'd3;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [FREQ_W-1:0] freq;
    } entry_t;

    typedef struct packed {
        logic   go;
        logic   allowed;
        logic   last;
        entry_t ent;
    } cand_t;

    function automatic logic [RATIO_W-1:0] ratio_rom(input logic [3:0] pc);
        logic [RATIO_W-1:0] r;
        begin
            case (pc)
                4'd0: r = 17'd65536;
                4'd1: r = 17'd69433;
                4'd2: r = 17'd73562;
                4'd3: r = 17'd77936;
                4'd4: r = 17'd82570;
                4'd5: r = 17'd87480;
                4'd6: r = 17'd92682;
                4'd7: r = 17'd98193;
                4'd8: r = 17'd104032;
                4'd9: r = 17'd110218;
                4'd10: r = 17'd116772;
                4'd11: r = 17'd123715;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction
endpackage

// ===== hdl/spq_cell.sv =====
// One cell of the allowed-note chain: holds one list entry and passes it on.
`timescale 1ns / 1ps
module spq_cell
    import spq_pkg::*;
(
    input  logic   clk,
    input  logic   shift_en,
    input  entry_t ent_in,
    output entry_t ent_out
);
    entry_t ent_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            ent_reg <= ent_in;
        end
    end

    assign ent_out = ent_reg;
endmodule

// ===== hdl/spq_note_gen.sv =====
// Walks the candidate notes, one per cycle, and computes frequency and omit flag.
`timescale 1ns / 1ps
module spq_note_gen
    import spq_pkg::*;
#(
    parameter int FIRST_NOTE = 13,
    parameter int NOTE_COUNT = 113
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        init,
    input  logic [8:0]  concert,
    input  logic [3:0]  key,
    input  logic [11:0] mask,
    output cand_t       cand
);
    localparam int NW = $clog2(NOTE_COUNT);
    localparam logic [3:0] NPC0 = 4'(FIRST_NOTE % 12);
    localparam logic [3:0] DPC0 = 4'((FIRST_NOTE + 3) % 12);
    localparam logic [3:0] DOCT0 = 4'((FIRST_NOTE + 3) / 12);

    logic [NW-1:0]     n_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [3:0]        npc_reg;
    logic [3:0]        dpc_reg;
    logic [3:0]        doct_reg;
    logic              act_reg;
    cand_t             cand_reg;

    logic [3:0]  key12;
    logic [3:0]  k;
    logic        last;
    logic [4:0]  s;
    logic [25:0] prod;
    logic [26:0] rounded;

    always_comb
    begin
        key12 = (key >= 4'd12) ? key - 4'd12 : key;
        k = (npc_reg >= key12) ? npc_reg - key12 : npc_reg + 4'd12 - key12;
        last = (n_reg == NW'(NOTE_COUNT - 1)) || (note_reg == 7'd127);
        s = 5'd18 - {1'b0, doct_reg};
        prod = 26'(concert) * 26'(ratio_rom(dpc_reg));
        rounded = (27'(prod) + (27'd1 << (s - 5'd1))) >> s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cand_reg.go <= 1'b0;
        end
        else if (init)
        begin
            act_reg <= 1'b1;
            cand_reg.go <= 1'b0;
            n_reg <= '0;
            note_reg <= NOTE_W'(FIRST_NOTE);
            npc_reg <= NPC0;
            dpc_reg <= DPC0;
            doct_reg <= DOCT0;
        end
        else
        begin
            cand_reg.go <= act_reg;
            if (act_reg)
            begin
                cand_reg.allowed <= !mask[k];
                cand_reg.last <= last;
                cand_reg.ent.note <= note_reg;
                cand_reg.ent.freq <= rounded[FREQ_W-1:0];
                act_reg <= !last;
                n_reg <= n_reg + 1'b1;
                note_reg <= note_reg + 1'b1;
                npc_reg <= (npc_reg == 4'd11) ? 4'd0 : npc_reg + 4'd1;
                if (dpc_reg == 4'd11)
                begin
                    dpc_reg <= 4'd0;
                    doct_reg <= doct_reg + 4'd1;
                end
                else
                begin
                    dpc_reg <= dpc_reg + 4'd1;
                end
            end
        end
    end

    assign cand = cand_reg;
endmodule

// ===== hdl/scale_pitch_quantizer.sv =====
// Top level of the scale pitch quantizer: control, band test and result.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------
//   input    | start, busy        | frequency_in
//   result   | done (one cycle)   | frequency_out, note_out, status
//   config   | cfg_we             | cfg_index, cfg_data
//
// The done strobe follows the last candidate note through fin_reg and done_reg
// (earlier when the note range reaches MIDI note 127), and the next item can
// be accepted at the edge that ends the strobe. The note generator walks one
// candidate note per cycle and its single multiplier sets that pace.
// Allowed notes shift through a chain of 33 cells, so the entry a negative
// step away from the matching band is still on hand when the band is found.
// Reset is asynchronous and returns the registers to their reset values.
// The result is shown for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
module scale_pitch_quantizer
    import spq_pkg::*;
#(
    parameter int FIRST_NOTE = 13,
    parameter int NOTE_COUNT = 113
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FREQ_W-1:0] frequency_in,
    output logic              done,
    output logic [FREQ_W-1:0] frequency_out,
    output logic [NOTE_W-1:0] note_out,
    output logic [1:0]        status,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [11:0]       cfg_data
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg;

    logic [8:0]        concert_reg;
    logic [3:0]        key_reg;
    logic [11:0]       omit_reg;
    logic signed [5:0] shift_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            concert_reg <= 9'd440;
            key_reg <= 4'd0;
            omit_reg <= 12'd0;
            shift_reg <= 6'sd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CONCERT: concert_reg <= cfg_data[8:0];
                REG_KEY: key_reg <= cfg_data[3:0];
                REG_OMIT: omit_reg <= cfg_data;
                REG_SHIFT: shift_reg <= $signed(cfg_data[5:0]);
                default: ;
            endcase
        end
    end

    logic accept;
    assign accept = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);

    cand_t cand;

    spq_note_gen #(
        .FIRST_NOTE(FIRST_NOTE),
        .NOTE_COUNT(NOTE_COUNT)
    ) u_gen (
        .clk(clk),
        .rst_n(rst_n),
        .init(accept),
        .concert(concert_reg),
        .key(key_reg),
        .mask(omit_reg),
        .cand(cand)
    );

    // Chain of allowed-note cells: cell 0 holds the newest listed entry.
    logic   ins;
    entry_t cells [CHAIN_LEN];

    assign ins = cand.go && cand.allowed;

    genvar gi;
    generate
        for (gi = 0; gi < CHAIN_LEN; gi++)
        begin : g_chain
            spq_cell u_cell (
                .clk(clk),
                .shift_en(ins),
                .ent_in((gi == 0) ? cand.ent : cells[(gi == 0) ? 0 : gi - 1]),
                .ent_out(cells[gi])
            );
        end
    endgenerate

    logic [FREQ_W:0]   x2_reg;
    logic [7:0]        cnt_reg;
    logic              found_reg;
    logic              pend_reg;
    logic              ok_reg;
    logic signed [9:0] tgt_reg;
    entry_t            res_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [FREQ_W-1:0] fout_reg;
    logic [NOTE_W-1:0] nout_reg;
    logic [1:0]        stat_reg;

    // Band test against the two newest entries and the incoming one.
    logic [FREQ_W:0]    lo;
    logic [FREQ_W:0]    hi;
    logic               hit;
    logic signed [9:0]  tgt;
    logic [KIDX_W-1:0]  kidx;

    always_comb
    begin
        lo = {1'b0, cells[1].freq} + {1'b0, cells[0].freq};
        hi = {1'b0, cells[0].freq} + {1'b0, cand.ent.freq};
        hit = ins && !found_reg && (cnt_reg >= 8'd2) && (lo <= x2_reg) && (x2_reg < hi);
        tgt = $signed({2'b00, cnt_reg - 8'd1}) + 10'(shift_reg);
        kidx = KIDX_W'(-shift_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            pend_reg <= 1'b0;
            ok_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 8'd0;
        end
        else
        begin
            fin_reg <= cand.go && cand.last;
            done_reg <= fin_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_RUN;
                        x2_reg <= {frequency_in, 1'b0};
                        cnt_reg <= 8'd0;
                        found_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        ok_reg <= 1'b0;
                    end
                end
                S_RUN:
                begin
                    if (ins)
                    begin
                        cnt_reg <= cnt_reg + 8'd1;
                    end
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        tgt_reg <= tgt;
                        if (shift_reg <= 6'sd0)
                        begin
                            // The target entry is already in the chain.
                            if (tgt >= 10'sd0)
                            begin
                                ok_reg <= 1'b1;
                                res_reg <= cells[kidx];
                            end
                        end
                        else if (shift_reg == 6'sd1)
                        begin
                            ok_reg <= 1'b1;
                            res_reg <= cand.ent;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                        end
                    end
                    else if (ins && pend_reg && ($signed({2'b00, cnt_reg}) == tgt_reg))
                    begin
                        pend_reg <= 1'b0;
                        ok_reg <= 1'b1;
                        res_reg <= cand.ent;
                    end
                    if (fin_reg)
                    begin
                        state_reg <= S_IDLE;
                        if (!found_reg)
                        begin
                            stat_reg <= ST_NOBAND;
                            fout_reg <= '0;
                            nout_reg <= '0;
                        end
                        else if (ok_reg)
                        begin
                            stat_reg <= ST_MATCH;
                            fout_reg <= res_reg.freq;
                            nout_reg <= res_reg.note;
                        end
                        else
                        begin
                            stat_reg <= ST_RANGE;
                            fout_reg <= '0;
                            nout_reg <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign frequency_out = fout_reg;
    assign note_out = nout_reg;
    assign status = stat_reg;

    // A result is strobed in the cycle after the walk has finished.
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |=> done_reg)
        else $error("done did not follow the end of the walk");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_MATCH) || (status == ST_NOBAND) || (status == ST_RANGE))
        else $error("status carries an unused code");

    a_zero_unless_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_MATCH) || (frequency_out == '0 && note_out == '0))
        else $error("payload not zero on a failed item");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");
endmodule

// ===== verif/tb_scale_pitch_quantizer.sv =====
// Self-checking testbench for the scale pitch quantizer.
`timescale 1ns / 1ps
module tb_scale_pitch_quantizer;
    import spq_pkg::*;

    // One expected result of the quantizer.
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [NOTE_W-1:0] note;
        logic [1:0]        st;
    } snap_t;

    // Scoreboard: holds the snapped notes still owed by the block.
    class snap_board;
        snap_t pending[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(snap_t s);
            pending.push_back(s);
        endfunction

        function void check_result(snap_t got);
            snap_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result f=%0d n=%0d s=%0d", $time,
                         got.freq, got.note, got.st);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.freq !== want.freq) begin
                $display("%0t: frequency_out expected %0d actual %0d", $time,
                         want.freq, got.freq);
                errors++;
            end
            if (got.note !== want.note) begin
                $display("%0t: note_out expected %0d actual %0d", $time,
                         want.note, got.note);
                errors++;
            end
            if (got.st !== want.st) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         want.st, got.st);
                errors++;
            end
        endfunction
    endclass

    localparam int LOW_NOTE   = 13;
    localparam int NOTE_SPAN  = 113;
    localparam int WATCHDOG   = 4000;
    localparam int TAIL_WAIT  = 200;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [FREQ_W-1:0] frequency_in;
    logic              done;
    logic [FREQ_W-1:0] frequency_out;
    logic [NOTE_W-1:0] note_out;
    logic [1:0]        status;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [11:0]       cfg_data;

    // Our copy of the configuration registers.
    logic [8:0]        pitch_a4;
    logic [3:0]        key_pc;
    logic [11:0]       drop_mask;
    logic signed [5:0] list_step;

    snap_board board;
    int        idle_cycles;
    bit        timed_out;

    scale_pitch_quantizer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .frequency_in(frequency_in), .done(done), .frequency_out(frequency_out),
        .note_out(note_out), .status(status), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Equal-tempered frequency of a MIDI note in 1/16 Hz, rounded half up.
    function automatic logic [FREQ_W-1:0] tone_freq(int note);
        int unsigned ratio[12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                   92682, 98193, 104032, 110218, 116772, 123715};
        int          d;
        int          sh;
        logic [63:0] prod;
        d = note + 3;
        sh = 18 - d / 12;
        prod = 64'(pitch_a4) * ratio[d % 12];
        prod = (prod + (64'd1 << (sh - 1))) >> sh;
        return prod[FREQ_W-1:0];
    endfunction

    // Builds the allowed-note list, finds the band of the input and applies
    // the list step.
    function automatic snap_t snap_pitch(logic [FREQ_W-1:0] f_in);
        int          notes[$];
        logic [19:0] freqs[$];
        logic [19:0] x2;
        int          hit;
        int          idx;
        int          k;
        snap_t       r;
        x2 = 20'(f_in) * 2;
        for (int n = LOW_NOTE; n < LOW_NOTE + NOTE_SPAN && n < 128; n++) begin
            k = (n % 12 + 12 - (key_pc % 12)) % 12;
            if (!drop_mask[k]) begin
                notes.push_back(n);
                freqs.push_back(20'(tone_freq(n)));
            end
        end
        hit = -1;
        for (int i = 1; i + 1 < notes.size(); i++) begin
            if (freqs[i-1] + freqs[i] <= x2 && x2 < freqs[i] + freqs[i+1]) begin
                hit = i;
                break;
            end
        end
        r = '0;
        if (hit < 0) begin
            r.st = ST_NOBAND;
        end
        else begin
            idx = hit + int'(list_step);
            if (idx < 0 || idx >= notes.size()) begin
                r.st = ST_RANGE;
            end
            else begin
                r.freq = freqs[idx][FREQ_W-1:0];
                r.note = NOTE_W'(notes[idx]);
                r.st = ST_MATCH;
            end
        end
        return r;
    endfunction

    // Writes one register; the block is idle whenever this is called.
    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CONCERT: pitch_a4 = val[8:0];
            REG_KEY:     key_pc = val[3:0];
            REG_OMIT:    drop_mask = val;
            default:     list_step = val[5:0];
        endcase
        @(posedge clk);
    endtask

    // Sends one item after a random gap, unless the gap is suppressed.
    task automatic send_item(logic [FREQ_W-1:0] f, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        repeat (gap) @(posedge clk);
        start <= 1'b1;
        frequency_in <= f;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_item(snap_pitch(f));
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every owed result has come, plus a margin for the block.
    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Picks a frequency near a random note so that most items land in a band.
    function automatic logic [FREQ_W-1:0] near_note();
        int          n;
        int          jit;
        logic [19:0] f;
        n = $urandom_range(LOW_NOTE, 127);
        f = 20'(tone_freq(n));
        jit = $urandom_range(0, 40) - 20;
        f = 20'(int'(f) + int'(f) * jit / 400);
        if (f > 20'h3FFFF) f = 20'h3FFFF;
        return f[FREQ_W-1:0];
    endfunction

    task automatic random_config();
        int pick;
        pick = $urandom_range(0, 9);
        write_reg(REG_CONCERT, pick == 0 ? 12'(400) : pick == 1 ? 12'(480) :
                  pick == 2 ? 12'($urandom_range(0, 511)) : 12'($urandom_range(400, 480)));
        write_reg(REG_KEY, 12'($urandom_range(0, 15)));
        pick = $urandom_range(0, 9);
        write_reg(REG_OMIT, pick == 0 ? 12'hFFF : pick == 1 ? 12'hFFE :
                  pick == 2 ? 12'h000 : 12'($urandom_range(0, 4095)));
        pick = $urandom_range(0, 9);
        write_reg(REG_SHIFT, pick == 0 ? 12'(6'sd16) : pick == 1 ? 12'(6'h30) :
                  12'($urandom_range(0, 63)));
    endtask

    // Accept every strobed result; the block holds it for one cycle only.
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            board.check_result('{freq: frequency_out, note: note_out, st: status});
        end
    end

    // Watchdog: counts cycles in which nothing is accepted.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || cfg_we) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG && !timed_out) begin
                timed_out = 1'b1;
                $display("tb_scale_pitch_quantizer failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [FREQ_W-1:0] edge_f[10];
        board = new();
        timed_out = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        frequency_in = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pitch_a4 = 9'd440;
        key_pc = 4'd0;
        drop_mask = 12'd0;
        list_step = 6'sd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset values: field extremes, band edges and
        // the lowest and highest notes, which own no band.
        edge_f = '{18'd0, 18'h3FFFF, 18'd7040, 18'd6999, 18'd560,
                   18'd582, 18'd200000, 18'd190000, 18'h2AAAA, 18'h15555};
        foreach (edge_f[i]) send_item(edge_f[i], i < 3);
        drain();
        // Big positive and negative steps, and steps off both list ends.
        write_reg(REG_SHIFT, 12'(6'sd16));
        send_item(18'd7040, 1'b0);
        send_item(18'd190000, 1'b0);
        drain();
        write_reg(REG_SHIFT, 12'(6'h30));
        send_item(18'd7040, 1'b0);
        send_item(18'd600, 1'b0);
        drain();
        // Key above eleven, a mask that leaves seven notes of the octave and extreme concert pitch.
        write_reg(REG_KEY, 12'd15);
        write_reg(REG_OMIT, 12'b0101_0010_1010);
        write_reg(REG_SHIFT, 12'd1);
        write_reg(REG_CONCERT, 12'd511);
        send_item(18'd7040, 1'b0);
        send_item(18'd250000, 1'b0);
        drain();
        // A single allowed pitch class at zero concert pitch, and then no allowed note, leave no band.
        write_reg(REG_OMIT, 12'hFFE);
        write_reg(REG_CONCERT, 12'd0);
        send_item(18'd0, 1'b0);
        send_item(18'd7040, 1'b0);
        drain();
        write_reg(REG_OMIT, 12'hFFF);
        send_item(18'd1000, 1'b0);
        drain();

        // Random phases, each under a fresh configuration.
        for (int phase = 0; phase < 30; phase++) begin
            random_config();
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(18'($urandom_range(0, 262143)), phase % 3 == 0);
                end
                else begin
                    send_item(near_note(), phase % 3 == 0);
                end
                // The sender sometimes holds off until all results are in.
                if (i == 15 && phase % 4 == 1) drain();
            end
            drain();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_scale_pitch_quantizer passed");
        end
        else begin
            $display("tb_scale_pitch_quantizer failed");
        end
        $finish;
    end
endmodule
